/* hw/rtl/mec_pkg.sv */
// MIDI event classifier package: payload structs, event kind and status codes,
// controller store sizing. No dependencies.
`timescale 1ns / 1ps

package mec_pkg;

  localparam int CONTROLLER_COUNT = 128;
  localparam int CTRL_IDX_W = (CONTROLLER_COUNT > 1) ? $clog2(CONTROLLER_COUNT) : 1;

  localparam logic [3:0] KIND_NOTE      = 4'd0;
  localparam logic [3:0] KIND_NOTE_DOWN = 4'd1;
  localparam logic [3:0] KIND_NOTE_UP   = 4'd2;
  localparam logic [3:0] KIND_CTRL      = 4'd3;
  localparam logic [3:0] KIND_CTRL_DOWN = 4'd4;
  localparam logic [3:0] KIND_CTRL_UP   = 4'd5;
  localparam logic [3:0] KIND_INCREASE  = 4'd6;
  localparam logic [3:0] KIND_DECREASE  = 4'd7;
  localparam logic [3:0] KIND_PROGRAM   = 4'd8;

  // upper nibble of the status byte
  localparam logic [3:0] STAT_NOTE_OFF = 4'h8;
  localparam logic [3:0] STAT_NOTE_ON  = 4'h9;
  localparam logic [3:0] STAT_CTRL     = 4'hB;
  localparam logic [3:0] STAT_PROGRAM  = 4'hC;

  localparam logic CFG_THRESHOLD = 1'b0;
  localparam logic CFG_HALTED    = 1'b1;

  localparam logic [6:0] THRESHOLD_RESET = 7'd64;

  typedef struct packed {
    logic       is_data;
    logic [7:0] status_byte;
    logic [6:0] first_data;
    logic [6:0] second_data;
  } mec_in_t;

  typedef struct packed {
    logic [3:0] event_kind;
    logic [6:0] event_number;
    logic       last_event;
  } mec_out_t;

endpackage

/* hw/rtl/midi_event_classifier.sv */
// MIDI event classifier top level: message decode, controller value store,
// event buffer and output register. Depends on mec_pkg.
`timescale 1ns / 1ps

// Each accepted MIDI short message yields zero to three events, sent one per
// cycle on the evt channel while evt_stall is low, the last flagged by last_event.
// A message passes the decode stage, then its events leave one by one on the
// single output port (three for a control change that crosses the threshold
// and moves); the next message may leave decode as the last event goes. The
// previous controller values live in a synchronous single-port-write memory
// read into a register on acceptance; a back-to-back write to one controller
// is forwarded. No clearing pass is needed: reset clears per-entry valid flops.
// Configuration: index 0 switch threshold, index 1 halt; cfg_ready is always high.
module midi_event_classifier import mec_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_stall,
  input  mec_in_t  req,
  output logic     evt_valid,
  input  logic     evt_stall,
  output mec_out_t evt,
  input  logic     cfg_valid,
  output logic     cfg_ready,
  input  logic     cfg_index,
  input  logic [6:0] cfg_data
);

  logic [6:0] threshold;
  logic       halted;

  logic [6:0] mem [CONTROLLER_COUNT];
  logic [CONTROLLER_COUNT-1:0] vld;
  logic [6:0] rd_q;

  logic     s1_valid;
  mec_in_t  s1;
  logic     s1_have;
  logic     s1_fwd;
  logic [6:0] s1_fwd_val;

  logic [3:0] buf_kind [3];
  logic [6:0] buf_num;
  logic [1:0] rem;

  logic acc, s1_adv, out_load;
  logic [CTRL_IDX_W-1:0] rd_idx, wr_idx;
  logic wr_en;
  logic [6:0] prev;
  logic now_on, was_on;
  logic [3:0] k [3];
  logic [1:0] n_ev;
  logic in_store_rd, in_store_s1;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THRESHOLD_RESET;
      halted    <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_THRESHOLD: threshold <= cfg_data;
        CFG_HALTED:    halted    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign out_load  = (rem != 2'd0) && (!evt_valid || !evt_stall);
  assign s1_adv    = s1_valid && ((rem == 2'd0) || (rem == 2'd1 && out_load));
  assign req_stall = s1_valid && !s1_adv;
  assign acc       = req_valid && !req_stall;

  assign rd_idx      = req.first_data[CTRL_IDX_W-1:0];
  assign wr_idx      = s1.first_data[CTRL_IDX_W-1:0];
  assign in_store_rd = {1'b0, req.first_data} < 8'(CONTROLLER_COUNT);
  assign in_store_s1 = {1'b0, s1.first_data} < 8'(CONTROLLER_COUNT);

  assign prev   = s1_fwd ? s1_fwd_val : rd_q;
  assign now_on = s1.second_data >= threshold;
  assign was_on = s1_have && (prev >= threshold);

  always_comb begin
    k[0] = KIND_NOTE;
    k[1] = KIND_NOTE;
    k[2] = KIND_NOTE;
    n_ev = 2'd0;
    if (!halted && s1.is_data) begin
      case (s1.status_byte[7:4])
        STAT_NOTE_OFF: begin
          k[0] = KIND_NOTE;
          k[1] = KIND_NOTE_UP;
          n_ev = 2'd2;
        end
        STAT_NOTE_ON: begin
          k[0] = KIND_NOTE;
          k[1] = (s1.second_data != 7'd0) ? KIND_NOTE_DOWN : KIND_NOTE_UP;
          n_ev = 2'd2;
        end
        STAT_CTRL: begin
          k[0] = KIND_CTRL;
          n_ev = 2'd1;
          if (now_on != was_on) begin
            k[1] = now_on ? KIND_CTRL_DOWN : KIND_CTRL_UP;
            n_ev = 2'd2;
          end
          if (s1_have && (s1.second_data != prev)) begin
            k[n_ev] = (s1.second_data > prev) ? KIND_INCREASE : KIND_DECREASE;
            n_ev = n_ev + 2'd1;
          end
        end
        STAT_PROGRAM: begin
          k[0] = KIND_PROGRAM;
          n_ev = 2'd1;
        end
        default: ;
      endcase
    end
  end

  assign wr_en = s1_adv && !halted && s1.is_data && in_store_s1 &&
                 (s1.status_byte[7:4] == STAT_CTRL);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= s1.second_data;
    end
    if (acc) begin
      rd_q <= mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld      <= '0;
      s1_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[wr_idx] <= 1'b1;
      end
      if (acc) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1         <= req;
      s1_fwd     <= wr_en && (wr_idx == rd_idx);
      s1_fwd_val <= s1.second_data;
      s1_have    <= in_store_rd && ((wr_en && (wr_idx == rd_idx)) || vld[rd_idx]);
    end
  end

  // event buffer, drained head first
  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= 2'd0;
    end else if (s1_adv) begin
      rem <= n_ev;
    end else if (out_load) begin
      rem <= rem - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      buf_kind[0] <= k[0];
      buf_kind[1] <= k[1];
      buf_kind[2] <= k[2];
      buf_num     <= s1.first_data;
    end else if (out_load) begin
      buf_kind[0] <= buf_kind[1];
      buf_kind[1] <= buf_kind[2];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      evt_valid <= 1'b0;
    end else if (out_load) begin
      evt_valid <= 1'b1;
    end else if (!evt_stall) begin
      evt_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      evt.event_kind   <= buf_kind[0];
      evt.event_number <= buf_num;
      evt.last_event   <= (rem == 2'd1);
    end
  end

  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    evt_valid |-> evt.event_kind <= KIND_PROGRAM)
    else $error("event kind out of range");

  a_buf_loaded: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && n_ev != 2'd0) |=> rem != 2'd0)
    else $error("events lost at buffer load");

  a_fwd: assert property (@(posedge clk) disable iff (rst)
    (acc && wr_en && wr_idx == rd_idx) |=> s1_fwd)
    else $error("missed forward of controller value");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && rem > 2'd1) |-> req_stall)
    else $error("decode stage overrun");

endmodule
